// ===== sv/bvm_pkg.sv =====
package bvm_pkg;

	localparam int SAMPLE_W = 12;
	localparam int SUM_W    = 16;
	localparam int CNT_W    = 4;
	localparam int MV_W     = 14;
	localparam int PCT_W    = 7;

	localparam int SAMPLE_COUNT_DEF = 10;

	// shift-add multiplier: 25-bit multiplicand, 12-bit multiplier
	localparam int MCAND_W   = 25;
	localparam int MPLIER_W  = 12;
	localparam int PROD_W    = MCAND_W + MPLIER_W;
	localparam int MUL_CNT_W = $clog2(MPLIER_W + 1);

	// restoring divider: one quotient bit per cycle
	localparam int DVD_W     = 21;
	localparam int DVS_W     = 14;
	localparam int DIV_CNT_W = $clog2(DVD_W + 1);

	// calibration in Q24, divider ratio in Q16
	localparam int ACC_W = PROD_W + 1;
	localparam logic [MCAND_W-1:0] CAL_C2_MAG = MCAND_W'(2984);
	localparam logic [MCAND_W-1:0] CAL_C1     = MCAND_W'(29925134);
	localparam logic [ACC_W-1:0]   CAL_B      = ACC_W'(64'd19213267763);
	localparam logic [MCAND_W-1:0] DIV_K      = MCAND_W'(283266);
	localparam int PIN_LSB = 24;
	localparam int MV_LSB  = 16;

	localparam logic [MV_W-1:0]  EMPTY_MV_RST = MV_W'(10900);
	localparam logic [MV_W-1:0]  FULL_MV_RST  = MV_W'(12460);
	localparam logic [PCT_W-1:0] PCT_ZERO     = PCT_W'(0);
	localparam logic [PCT_W-1:0] PCT_ONE      = PCT_W'(1);
	localparam logic [PCT_W-1:0] PCT_FULL     = PCT_W'(100);

	typedef enum logic [0:0] {
		REG_EMPTY_MV = 1'b0,
		REG_FULL_MV  = 1'b1
	} cfg_reg_t;

endpackage

// ===== sv/bvm_serial_mul.sv =====
module bvm_serial_mul (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [bvm_pkg::MCAND_W-1:0]   mcand,
	input  logic [bvm_pkg::MPLIER_W-1:0]  mplier,
	output logic                          done,
	output logic [bvm_pkg::PROD_W-1:0]    prod
);

	logic                            busy_q;
	logic                            done_q;
	logic [bvm_pkg::MUL_CNT_W-1:0]   cnt_q;
	logic [bvm_pkg::MCAND_W-1:0]     mcand_q;
	logic [bvm_pkg::PROD_W-1:0]      prod_q;
	logic [bvm_pkg::MCAND_W:0]       part_sum;

	// upper half plus the multiplicand when the current multiplier bit is set
	assign part_sum = {1'b0, prod_q[bvm_pkg::PROD_W-1:bvm_pkg::MPLIER_W]}
		+ (prod_q[0] ? {1'b0, mcand_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == bvm_pkg::MUL_CNT_W'(bvm_pkg::MPLIER_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q <= mcand;
			prod_q  <= {{bvm_pkg::MCAND_W{1'b0}}, mplier};
		end else if (busy_q) begin
			prod_q <= {part_sum, prod_q[bvm_pkg::MPLIER_W-1:1]};
		end
	end

	assign done = done_q;
	assign prod = prod_q;

endmodule

// ===== sv/bvm_serial_div.sv =====
module bvm_serial_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [bvm_pkg::DVD_W-1:0]   dividend,
	input  logic [bvm_pkg::DVS_W-1:0]   divisor,
	output logic                        done,
	output logic [bvm_pkg::DVD_W-1:0]   quo
);

	logic                            busy_q;
	logic                            done_q;
	logic [bvm_pkg::DIV_CNT_W-1:0]   cnt_q;
	logic [bvm_pkg::DVS_W-1:0]       dvs_q;
	logic [bvm_pkg::DVS_W-1:0]       rem_q;
	logic [bvm_pkg::DVD_W-1:0]       quo_q;
	logic [bvm_pkg::DVS_W:0]         trial;
	logic [bvm_pkg::DVS_W+1:0]       diff;
	logic                            fits;

	assign trial = {rem_q, quo_q[bvm_pkg::DVD_W-1]};
	assign diff  = {1'b0, trial} - {2'b00, dvs_q};
	assign fits  = !diff[bvm_pkg::DVS_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == bvm_pkg::DIV_CNT_W'(bvm_pkg::DVD_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// restore on borrow: keep the trial remainder, shift in a zero
	always_ff @(posedge clk) begin
		if (start) begin
			dvs_q <= divisor;
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? diff[bvm_pkg::DVS_W-1:0] : trial[bvm_pkg::DVS_W-1:0];
			quo_q <= {quo_q[bvm_pkg::DVD_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

// ===== sv/battery_voltage_monitor.sv =====
// Battery voltage monitor: block average of raw converter samples, quadratic
// calibration to pin millivolts, divider-ratio scaling and a charge percentage.
// Input channel (in_valid/in_stall, adc_sample): the first SAMPLE_COUNT beats
// are summed, one beat per cycle, and produce no result. The next beat is
// dropped and starts the evaluation; in_stall stays high until it finishes.
// Evaluation runs a restoring divide for the mean, three shift-add multiplies for
// the polynomial and the scaling, and a second divide for the percentage, all one
// bit per cycle; the second divide is skipped when the percentage is set directly
// to 0, 100 or 1. in_stall falls in the same cycle that out_valid rises, so the
// next input beat can be taken from that cycle on.
// Output channel (out_valid/out_stall): one beat carries average_reading,
// battery_mv and battery_percent from an output register. While it is stalled
// the payload holds and summing of new samples goes on; a finished evaluation
// waits for the register to drain before the block takes another beat.
// Configuration (cfg_wr_en/cfg_index/cfg_wdata) writes empty_mv (index 0) or
// full_mv (index 1); write only while the block is idle.
// Reset clears the sum, the count and the output valid and loads the
// default thresholds 10900 mV and 12460 mV.
module battery_voltage_monitor #(
	parameter int SAMPLE_COUNT = bvm_pkg::SAMPLE_COUNT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [bvm_pkg::SAMPLE_W-1:0]  adc_sample,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [bvm_pkg::SAMPLE_W-1:0]  average_reading,
	output logic [bvm_pkg::MV_W-1:0]      battery_mv,
	output logic [bvm_pkg::PCT_W-1:0]     battery_percent,
	input  logic                          cfg_wr_en,
	input  logic [0:0]                    cfg_index,
	input  logic [bvm_pkg::MV_W-1:0]      cfg_wdata
);

	typedef enum logic [7:0] {
		S_IDLE    = 8'b0000_0001,
		S_DIV_AVG = 8'b0000_0010,
		S_MUL1    = 8'b0000_0100,
		S_MUL2    = 8'b0000_1000,
		S_MUL3    = 8'b0001_0000,
		S_PCT     = 8'b0010_0000,
		S_DIV_PCT = 8'b0100_0000,
		S_OUT     = 8'b1000_0000
	} state_t;

	state_t                            state_q;
	logic [bvm_pkg::MV_W-1:0]          empty_q;
	logic [bvm_pkg::MV_W-1:0]          full_q;
	logic [bvm_pkg::SUM_W-1:0]         sum_q;
	logic [bvm_pkg::CNT_W-1:0]         count_q;
	logic [bvm_pkg::SAMPLE_W-1:0]      avg_q;
	logic [bvm_pkg::MV_W-1:0]          mv_q;
	logic [bvm_pkg::PCT_W-1:0]         pct_q;
	logic                              out_valid_q;
	logic [bvm_pkg::SAMPLE_W-1:0]      avg_out_q;
	logic [bvm_pkg::MV_W-1:0]          mv_out_q;
	logic [bvm_pkg::PCT_W-1:0]         pct_out_q;

	logic                              in_accept;
	logic                              avg_step;
	logic                              out_free;

	logic                              mul_start;
	logic [bvm_pkg::MCAND_W-1:0]       mul_mcand;
	logic [bvm_pkg::MPLIER_W-1:0]      mul_mplier;
	logic                              mul_done;
	logic [bvm_pkg::PROD_W-1:0]        mul_prod;

	logic                              div_start;
	logic [bvm_pkg::DVD_W-1:0]         div_dividend;
	logic [bvm_pkg::DVS_W-1:0]         div_divisor;
	logic                              div_done;
	logic [bvm_pkg::DVD_W-1:0]         div_quo;

	logic [bvm_pkg::ACC_W-1:0]         cal_acc;
	logic                              cal_neg;
	logic [bvm_pkg::MPLIER_W-1:0]      pin_mv;
	logic [bvm_pkg::MV_W:0]            mv_raw;
	logic [bvm_pkg::MV_W-1:0]          mv_sat;
	logic                              below_empty;
	logic                              above_full;
	logic                              span_zero;
	logic [bvm_pkg::DVD_W-1:0]         pct_over;
	logic [bvm_pkg::DVD_W-1:0]         pct_dividend;

	assign in_stall  = (state_q != S_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign avg_step  = (count_q >= bvm_pkg::CNT_W'(SAMPLE_COUNT));
	assign out_free  = !out_valid_q || !out_stall;

	// c2*a^2 + c1*a - b evaluated as a*(c1 - |c2|*a) - b
	assign cal_acc = {1'b0, mul_prod} - bvm_pkg::CAL_B;
	assign cal_neg = cal_acc[bvm_pkg::ACC_W-1];
	assign pin_mv  = cal_acc[bvm_pkg::PIN_LSB +: bvm_pkg::MPLIER_W];

	assign mv_raw = mul_prod[bvm_pkg::MV_LSB +: bvm_pkg::MV_W + 1];
	assign mv_sat = mv_raw[bvm_pkg::MV_W] ? '1 : mv_raw[bvm_pkg::MV_W-1:0];

	assign below_empty = (mv_q < empty_q);
	assign above_full  = (mv_q > full_q);
	assign span_zero   = (full_q == empty_q);

	// (v - empty) * 99 as shifts and adds
	assign pct_over     = bvm_pkg::DVD_W'(mv_q - empty_q);
	assign pct_dividend = (pct_over << 6) + (pct_over << 5) + (pct_over << 1) + pct_over;

	always_comb begin
		mul_start    = 1'b0;
		mul_mcand    = '0;
		mul_mplier   = '0;
		div_start    = 1'b0;
		div_dividend = '0;
		div_divisor  = '0;
		case (state_q)
			S_IDLE: begin
				if (in_accept && avg_step) begin
					div_start    = 1'b1;
					div_dividend = bvm_pkg::DVD_W'(sum_q);
					div_divisor  = bvm_pkg::DVS_W'(SAMPLE_COUNT);
				end
			end
			S_DIV_AVG: begin
				if (div_done) begin
					mul_start  = 1'b1;
					mul_mcand  = bvm_pkg::CAL_C2_MAG;
					mul_mplier = div_quo[bvm_pkg::SAMPLE_W-1:0];
				end
			end
			S_MUL1: begin
				if (mul_done) begin
					mul_start  = 1'b1;
					mul_mcand  = bvm_pkg::CAL_C1 - mul_prod[bvm_pkg::MCAND_W-1:0];
					mul_mplier = avg_q;
				end
			end
			S_MUL2: begin
				if (mul_done) begin
					// a negative pin voltage scales to zero anyway
					mul_start  = 1'b1;
					mul_mcand  = bvm_pkg::DIV_K;
					mul_mplier = cal_neg ? '0 : pin_mv;
				end
			end
			S_PCT: begin
				if (!below_empty && !above_full && !span_zero) begin
					div_start    = 1'b1;
					div_dividend = pct_dividend;
					div_divisor  = full_q - empty_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sum_q   <= '0;
			count_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_accept) begin
						if (avg_step) begin
							sum_q   <= '0;
							count_q <= '0;
							state_q <= S_DIV_AVG;
						end else begin
							sum_q   <= sum_q + bvm_pkg::SUM_W'(adc_sample);
							count_q <= count_q + 1'b1;
						end
					end
				end
				S_DIV_AVG: if (div_done) state_q <= S_MUL1;
				S_MUL1:    if (mul_done) state_q <= S_MUL2;
				S_MUL2:    if (mul_done) state_q <= S_MUL3;
				S_MUL3:    if (mul_done) state_q <= S_PCT;
				S_PCT: begin
					if (below_empty || above_full || span_zero) begin
						state_q <= S_OUT;
					end else begin
						state_q <= S_DIV_PCT;
					end
				end
				S_DIV_PCT: if (div_done) state_q <= S_OUT;
				S_OUT:     if (out_free) state_q <= S_IDLE;
				default:   state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DIV_AVG && div_done) begin
			avg_q <= div_quo[bvm_pkg::SAMPLE_W-1:0];
		end
		if (state_q == S_MUL3 && mul_done) begin
			mv_q <= mv_sat;
		end
		if (state_q == S_PCT) begin
			if (below_empty) begin
				pct_q <= bvm_pkg::PCT_ZERO;
			end else if (above_full) begin
				pct_q <= bvm_pkg::PCT_FULL;
			end else if (span_zero) begin
				pct_q <= bvm_pkg::PCT_ONE;
			end
		end
		if (state_q == S_DIV_PCT && div_done) begin
			pct_q <= div_quo[bvm_pkg::PCT_W-1:0] + bvm_pkg::PCT_ONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			empty_q <= bvm_pkg::EMPTY_MV_RST;
			full_q  <= bvm_pkg::FULL_MV_RST;
		end else if (cfg_wr_en) begin
			case (bvm_pkg::cfg_reg_t'(cfg_index))
				bvm_pkg::REG_EMPTY_MV: empty_q <= cfg_wdata;
				bvm_pkg::REG_FULL_MV:  full_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// output register: load when the previous beat is gone or leaving
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && out_free) begin
			avg_out_q <= avg_q;
			mv_out_q  <= mv_q;
			pct_out_q <= pct_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign average_reading = avg_out_q;
	assign battery_mv      = mv_out_q;
	assign battery_percent = pct_out_q;

	bvm_serial_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.mcand  (mul_mcand),
		.mplier (mul_mplier),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	bvm_serial_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quo      (div_quo)
	);

endmodule
